### src/modbus_rtu_request_framer_macros.svh
// Assertion macros used by the framer top level.
`ifndef MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_MACROS_SVH

`ifndef SYNTH
// Checks a condition at every clock edge outside reset.
`define MRF_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("framer assertion failed");
// Checks that a trigger is followed by a condition at the next edge.
`define MRF_ASSERT_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("framer sequence assertion failed");
`else
`define MRF_ASSERT(label, cond)
`define MRF_ASSERT_NEXT(label, trig, cons)
`endif

`endif

### src/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

  localparam int unsigned MAX_WRITE_REGS = 123;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;

  // Depth of the command queue between the front and back parts.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    MODE_FC03     = 3'd0,
    MODE_FC04     = 3'd1,
    MODE_FC06     = 3'd2,
    MODE_FC16_HDR = 3'd3,
    MODE_FC16_VAL = 3'd4
  } mode_t;

  // One burst of frame bytes for the back part to send.
  typedef struct packed {
    logic [6:0][7:0] data;       // payload bytes, data[0] goes first
    logic [2:0]      n_data;     // number of payload bytes
    logic            crc_init;   // restart the CRC at the first byte
    logic            crc_append; // send the CRC after the payload
    logic            rejected;   // one zero byte marked rejected
  } cmd_t;

  // FC16 bookkeeping held by the front part.
  typedef struct packed {
    logic       frame_open;
    logic [6:0] words_left;
  } status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/modbus_rtu_request_framer.sv
// Modbus RTU master request framer.
// Input queue port: drive in_mode and the other in_ fields with in_push high;
// the transaction is taken at a clock edge where in_full is low. Result queue
// port: while out_empty is low, out_tx_byte and its flags show the oldest
// frame byte, taken at an edge where out_pop is high.
// Every input transaction yields 8 bytes (FC03/FC04/FC06), 7 (FC16 header),
// 2 or 4 (FC16 value, the last value adds the CRC) or one rejected result.
// Throughput is one byte per clock unless the receiver stalls; the single
// CRC-16 byte unit in the back part sets that rate. The first byte of an item
// passes through the command queue and then the output register on its way
// to the result port. Inputs are accepted while the four-entry command queue
// has room, even while a finished byte waits to be popped. When the receiver
// stalls, the output register holds its byte, the back part stops, and the
// queue fills until in_full rises. Synchronous reset closes any open FC16
// frame, empties the queue and the output register, and restarts the CRC at
// 0xFFFF.
`default_nettype none

module modbus_rtu_request_framer import mrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_slave_address,
  input  wire logic [15:0] in_register_address,
  input  wire logic [15:0] in_quantity,
  input  wire logic [15:0] in_data_word,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_last_of_run,
  output logic             out_end_of_frame,
  output logic             out_rejected
);

`include "modbus_rtu_request_framer_macros.svh"

  // Front to queue.
  logic    q_push;
  cmd_t    q_cmd_in;
  logic    q_full;
  status_t front_status;

  // Queue to back.
  logic    q_pop;
  cmd_t    q_cmd_out;
  logic    q_empty;

  // Shape that every rejected result must have.
  logic    reject_shape_ok;

  assign in_full = q_full;
  assign reject_shape_ok = out_last_of_run && !out_end_of_frame && (out_tx_byte == 8'd0);

  // The front part classifies each transaction and tracks the open FC16 frame.
  mrf_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (in_push),
    .mode             (in_mode),
    .slave_address    (in_slave_address),
    .register_address (in_register_address),
    .quantity         (in_quantity),
    .data_word        (in_data_word),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_cmd_in),
    .status           (front_status)
  );

  // The short queue lets the front and back parts stall independently.
  mrf_cmd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .cmd_in  (q_cmd_in),
    .full    (q_full),
    .pop     (q_pop),
    .cmd_out (q_cmd_out),
    .empty   (q_empty)
  );

  // The back part serializes bytes, runs the CRC and owns the output register.
  mrf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (q_cmd_out),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_tx_byte      (out_tx_byte),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_frame (out_end_of_frame),
    .out_rejected     (out_rejected)
  );

  // An open FC16 frame always expects at least one more value.
  `MRF_ASSERT(a_open_has_words, front_status.frame_open == (front_status.words_left != 7'd0))
  // A rejected result is a lone zero byte that ends its run and no frame.
  `MRF_ASSERT(a_reject_shape, out_empty || !out_rejected || reject_shape_ok)
  // The CRC high byte closing a frame is always the last byte of its run.
  `MRF_ASSERT(a_eof_is_last, out_empty || !out_end_of_frame || out_last_of_run)
  // A value that closes a frame must leave the front with no frame open.
  `MRF_ASSERT_NEXT(a_close_clears, q_push && q_cmd_in.crc_append, !front_status.frame_open)

endmodule

`default_nettype wire

### src/mrf_front.sv
`default_nettype none

module mrf_front import mrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic [2:0]  mode,
  input  wire logic [7:0]  slave_address,
  input  wire logic [15:0] register_address,
  input  wire logic [15:0] quantity,
  input  wire logic [15:0] data_word,
  input  wire logic        q_full,
  output logic             q_push,
  output cmd_t             q_cmd,
  output status_t          status
);

  logic       frame_open_r, frame_open_nxt;
  logic [6:0] words_left_r, words_left_nxt;
  logic       bad_count;
  logic [6:0] words_dec;

  assign q_push    = push & ~q_full;
  assign bad_count = (quantity == 16'd0) || (quantity > 16'(MAX_WRITE_REGS));
  assign words_dec = words_left_r - 7'd1;
  assign status    = '{frame_open: frame_open_r, words_left: words_left_r};

  always_comb begin
    q_cmd          = '0;
    frame_open_nxt = frame_open_r;
    words_left_nxt = words_left_r;
    case (mode)
      MODE_FC03, MODE_FC04, MODE_FC06: begin
        frame_open_nxt   = 1'b0;
        words_left_nxt   = '0;
        q_cmd.data[0]    = slave_address;
        q_cmd.data[1]    = (mode == MODE_FC03) ? FC_READ_HOLDING :
                           (mode == MODE_FC04) ? FC_READ_INPUT : FC_WRITE_SINGLE;
        q_cmd.data[2]    = register_address[15:8];
        q_cmd.data[3]    = register_address[7:0];
        q_cmd.data[4]    = (mode == MODE_FC06) ? data_word[15:8] : quantity[15:8];
        q_cmd.data[5]    = (mode == MODE_FC06) ? data_word[7:0] : quantity[7:0];
        q_cmd.n_data     = 3'd6;
        q_cmd.crc_init   = 1'b1;
        q_cmd.crc_append = 1'b1;
      end
      MODE_FC16_HDR: begin
        frame_open_nxt = 1'b0;
        words_left_nxt = '0;
        if (bad_count) begin
          q_cmd.n_data   = 3'd1;
          q_cmd.rejected = 1'b1;
        end else begin
          frame_open_nxt = 1'b1;
          words_left_nxt = quantity[6:0];
          q_cmd.data[0]  = slave_address;
          q_cmd.data[1]  = FC_WRITE_MULTI;
          q_cmd.data[2]  = register_address[15:8];
          q_cmd.data[3]  = register_address[7:0];
          q_cmd.data[4]  = quantity[15:8];
          q_cmd.data[5]  = quantity[7:0];
          q_cmd.data[6]  = {quantity[6:0], 1'b0};
          q_cmd.n_data   = 3'd7;
          q_cmd.crc_init = 1'b1;
        end
      end
      MODE_FC16_VAL: begin
        if (!frame_open_r || words_left_r == 7'd0) begin
          q_cmd.n_data   = 3'd1;
          q_cmd.rejected = 1'b1;
        end else begin
          q_cmd.data[0] = data_word[15:8];
          q_cmd.data[1] = data_word[7:0];
          q_cmd.n_data  = 3'd2;
          if (words_dec == 7'd0) begin
            q_cmd.crc_append = 1'b1;
            frame_open_nxt   = 1'b0;
            words_left_nxt   = '0;
          end else begin
            words_left_nxt = words_dec;
          end
        end
      end
      default: begin
        q_cmd.n_data   = 3'd1;
        q_cmd.rejected = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      words_left_r <= '0;
    end else if (q_push) begin
      frame_open_r <= frame_open_nxt;
      words_left_r <= words_left_nxt;
    end
  end

endmodule

`default_nettype wire

### src/mrf_cmd_queue.sv
`default_nettype none

module mrf_cmd_queue import mrf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t cmd_in,
  output logic      full,
  input  wire logic pop,
  output cmd_t      cmd_out,
  output logic      empty
);

  cmd_t             mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;

  assign full    = (count_r == (QAW+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign cmd_out = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### src/mrf_back.sv
`default_nettype none

module mrf_back import mrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_tx_byte,
  output logic             out_last_of_run,
  output logic             out_end_of_frame,
  output logic             out_rejected
);

  logic [2:0]  idx_r, idx_nxt;
  logic [15:0] crc_r;
  logic [15:0] crc_base;
  logic [3:0]  total;
  logic [2:0]  last_idx;
  logic        is_data, is_last, advance;
  logic [7:0]  cur_byte;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        last_r, eof_r, rej_r;

  assign total    = {1'b0, cmd.n_data} + (cmd.crc_append ? 4'd2 : 4'd0);
  assign last_idx = 3'(total - 4'd1);
  assign is_data  = (idx_r < cmd.n_data);
  assign is_last  = (idx_r == last_idx);
  assign advance  = !q_empty && (!valid_r || out_pop);
  assign q_pop    = advance && is_last;
  assign idx_nxt  = is_last ? 3'd0 : idx_r + 3'd1;
  assign crc_base = (idx_r == 3'd0 && cmd.crc_init) ? CRC_INIT : crc_r;

  always_comb begin
    if (is_data) begin
      cur_byte = cmd.data[idx_r];
    end else if (idx_r == cmd.n_data) begin
      cur_byte = crc_r[7:0];
    end else begin
      cur_byte = crc_r[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      crc_r   <= CRC_INIT;
      valid_r <= 1'b0;
    end else begin
      if (advance) begin
        idx_r   <= idx_nxt;
        valid_r <= 1'b1;
        if (is_data && !cmd.rejected) begin
          crc_r <= crc16_byte(crc_base, cur_byte);
        end
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      eof_r  <= is_last && cmd.crc_append;
      rej_r  <= cmd.rejected;
    end
  end

  assign out_empty        = ~valid_r;
  assign out_tx_byte      = byte_r;
  assign out_last_of_run  = last_r;
  assign out_end_of_frame = eof_r;
  assign out_rejected     = rej_r;

endmodule

`default_nettype wire

### test/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker import mrf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_push,
  input logic        in_full,
  input logic [2:0]  in_mode,
  input logic [7:0]  in_slave_address,
  input logic [15:0] in_register_address,
  input logic [15:0] in_quantity,
  input logic [15:0] in_data_word,
  input logic        out_empty,
  input logic        out_pop,
  input logic [7:0]  out_tx_byte,
  input logic        out_last_of_run,
  input logic        out_end_of_frame,
  input logic        out_rejected,
  output int         mismatches,
  output int         pending
);

  typedef struct {
    logic [7:0] tx_byte;
    logic       last_of_run;
    logic       end_of_frame;
    logic       rejected;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  int          error_total = 0;

  // Open FC16 frame as the framer should see it.
  logic [15:0] write_crc;
  logic [6:0]  regs_left;
  logic        write_open;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    repeat (8) c = (c >> 1) ^ ({16{c[0]}} & CRC_POLY);
    return c;
  endfunction

  function automatic void clear_write_frame();
    write_crc  = CRC_INIT;
    regs_left  = '0;
    write_open = 1'b0;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic last, input logic eof,
                                     input logic rej);
    expected_bytes.push_back('{b, last, eof, rej});
  endfunction

  function automatic void predict_frame_bytes(input logic [2:0] mode, input logic [7:0] addr,
                                              input logic [15:0] start_reg,
                                              input logic [15:0] qty, input logic [15:0] word);
    logic [7:0]  frame [8];
    logic [15:0] crc;
    logic [15:0] field;
    logic [7:0]  fc;
    crc = CRC_INIT;
    case (mode)
      MODE_FC03, MODE_FC04, MODE_FC06: begin
        clear_write_frame();
        fc = (mode == MODE_FC03) ? FC_READ_HOLDING :
             (mode == MODE_FC04) ? FC_READ_INPUT : FC_WRITE_SINGLE;
        field = (mode == MODE_FC06) ? word : qty;
        frame = '{addr, fc, start_reg[15:8], start_reg[7:0], field[15:8], field[7:0],
                  8'h00, 8'h00};
        for (int i = 0; i < 6; i++) crc = crc16_update(crc, frame[i]);
        frame[6] = crc[7:0];
        frame[7] = crc[15:8];
        for (int i = 0; i < 8; i++) queue_byte(frame[i], i == 7, i == 7, 1'b0);
      end
      MODE_FC16_HDR: begin
        clear_write_frame();
        if (qty == 16'd0 || qty > MAX_WRITE_REGS) begin
          queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
        end else begin
          frame = '{addr, FC_WRITE_MULTI, start_reg[15:8], start_reg[7:0], qty[15:8], qty[7:0],
                    {qty[6:0], 1'b0}, 8'h00};
          for (int i = 0; i < 7; i++) begin
            crc = crc16_update(crc, frame[i]);
            queue_byte(frame[i], i == 6, 1'b0, 1'b0);
          end
          write_crc  = crc;
          regs_left  = qty[6:0];
          write_open = 1'b1;
        end
      end
      MODE_FC16_VAL: begin
        if (!write_open || regs_left == 7'd0) begin
          // A value with no open frame leaves the state alone.
          queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
        end else begin
          crc = crc16_update(crc16_update(write_crc, word[15:8]), word[7:0]);
          regs_left = regs_left - 7'd1;
          queue_byte(word[15:8], 1'b0, 1'b0, 1'b0);
          if (regs_left != 7'd0) begin
            write_crc = crc;
            queue_byte(word[7:0], 1'b1, 1'b0, 1'b0);
          end else begin
            queue_byte(word[7:0], 1'b0, 1'b0, 1'b0);
            queue_byte(crc[7:0], 1'b0, 1'b0, 1'b0);
            queue_byte(crc[15:8], 1'b1, 1'b1, 1'b0);
            clear_write_frame();
          end
        end
      end
      default: queue_byte(8'h00, 1'b1, 1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_total++;
    end
  endfunction

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      clear_write_frame();
      expected_bytes.delete();
    end else begin
      // Results first: a transaction accepted at this edge cannot have output yet.
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected result: tx_byte %0h with nothing expected", out_tx_byte);
          error_total++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("tx_byte", want.tx_byte, out_tx_byte);
          check_field("last_of_run", want.last_of_run, out_last_of_run);
          check_field("end_of_frame", want.end_of_frame, out_end_of_frame);
          check_field("rejected", want.rejected, out_rejected);
        end
      end
      if (in_push && !in_full)
        predict_frame_bytes(in_mode, in_slave_address, in_register_address, in_quantity,
                            in_data_word);
    end
    mismatches <= error_total;
    pending    <= expected_bytes.size();
  end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import mrf_pkg::*;

  // Cycles with no transaction on either side before the run is declared hung.
  // The receiver never stalls for long, so this is far above any quiet stretch
  // of a correct run.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 410;
  // Quiet time after the last expected byte, long enough for a stray byte to
  // reach the output even through the longest receiver stall.
  localparam int DRAIN_CYCLES   = 40;
  // Mode codes that the framer does not know and has to reject.
  localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
  localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [2:0]  in_mode = MODE_FC03;
  logic [7:0]  in_slave_address = '0;
  logic [15:0] in_register_address = '0;
  logic [15:0] in_quantity = '0;
  logic [15:0] in_data_word = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last_of_run;
  logic        out_end_of_frame;
  logic        out_rejected;

  int mismatches;
  int pending;
  int in_accepts = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  int burst_left = 0;

  modbus_rtu_request_framer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_quantity         (in_quantity),
    .in_data_word        (in_data_word),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_tx_byte         (out_tx_byte),
    .out_last_of_run     (out_last_of_run),
    .out_end_of_frame    (out_end_of_frame),
    .out_rejected        (out_rejected)
  );

  // The checker sees the same pins as the framer and keeps its own model of
  // the frame bytes each transaction should produce.
  frame_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_mode             (in_mode),
    .in_slave_address    (in_slave_address),
    .in_register_address (in_register_address),
    .in_quantity         (in_quantity),
    .in_data_word        (in_data_word),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_tx_byte         (out_tx_byte),
    .out_last_of_run     (out_last_of_run),
    .out_end_of_frame    (out_end_of_frame),
    .out_rejected        (out_rejected),
    .mismatches          (mismatches),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Counts accepted input transactions for the sender, and ends the run if
  // neither side has moved anything for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_push && !in_full)
        in_accepts <= in_accepts + 1;
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver changes its habits after each random span: sometimes it pops
  // every byte, sometimes at random, and sometimes only when its span count is a
  // multiple of twelve, which backs the command queue up until in_full rises.
  int pop_style = 0;
  int pop_span = 0;
  always @(negedge clk) begin
    if (pop_span == 0) begin
      pop_style = $urandom_range(0, 3);
      pop_span = $urandom_range(20, 80);
    end
    pop_span--;
    case (pop_style)
      0: out_pop = 1'b1;
      1: out_pop = $urandom_range(0, 1);
      2: out_pop = ($urandom_range(0, 3) != 0);
      default: out_pop = (pop_span % 12 == 0);
    endcase
  end

  // Offers one input transaction and returns at the falling edge after it was
  // taken. The sender works in bursts; a new burst may start after a gap with
  // push low, or straight away.
  task automatic push_request(input logic [2:0] mode, input logic [7:0] addr,
                              input logic [15:0] start_reg, input logic [15:0] qty,
                              input logic [15:0] word);
    int gap;
    int target;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_push = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_push = 1'b1;
    in_mode = mode;
    in_slave_address = addr;
    in_register_address = start_reg;
    in_quantity = qty;
    in_data_word = word;
    target = in_accepts + 1;
    do @(negedge clk); while (in_accepts < target);
    items_sent++;
  endtask

  task automatic send_read_or_write();
    logic [2:0] mode;
    case ($urandom_range(0, 2))
      0: mode = MODE_FC03;
      1: mode = MODE_FC04;
      default: mode = MODE_FC06;
    endcase
    push_request(mode, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  // FC16 header whose count is zero or above the limit.
  task automatic send_bad_header();
    logic [15:0] qty;
    qty = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(MAX_WRITE_REGS + 1, 65535));
    push_request(MODE_FC16_HDR, $urandom(), $urandom(), qty, $urandom());
  endtask

  task automatic send_value();
    push_request(MODE_FC16_VAL, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic send_unknown_mode();
    push_request(3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI)), $urandom(), $urandom(),
                 $urandom(), $urandom());
  endtask

  // A multiple-register write: the header and its values, now and then cut
  // short by another command so that the open frame is abandoned.
  task automatic send_write_sequence(input int count);
    push_request(MODE_FC16_HDR, $urandom(), $urandom(), 16'(count), $urandom());
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        if ($urandom_range(0, 1) == 0)
          send_read_or_write();
        else
          send_bad_header();
        return;
      end
      send_value();
    end
    // A value after the frame closed is a stray one.
    if ($urandom_range(0, 7) == 0)
      send_value();
  endtask

  initial begin
    int pick;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes for the single-frame commands.
    push_request(MODE_FC03, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_FC04, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_request(MODE_FC06, 8'h01, 16'h0000, 16'h0000, 16'hFFFF);
    push_request(MODE_FC06, 8'hFE, 16'hFFFF, 16'hFFFF, 16'h0000);
    // A value with no frame open, and every unknown mode.
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'h1234);
    for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
      push_request(3'(m), 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // Bad FC16 counts: zero, one above the limit, and the largest value.
    push_request(MODE_FC16_HDR, 8'h11, 16'h0100, 16'h0000, 16'h0000);
    push_request(MODE_FC16_HDR, 8'h11, 16'h0100, 16'(MAX_WRITE_REGS + 1), 16'h0000);
    push_request(MODE_FC16_HDR, 8'h11, 16'h0100, 16'hFFFF, 16'h0000);
    // Shortest complete FC16 frame.
    push_request(MODE_FC16_HDR, 8'h7F, 16'hFFFF, 16'h0001, 16'h0000);
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'hFFFF);
    // An open frame abandoned by a read; its next value is then a stray one.
    push_request(MODE_FC16_HDR, 8'h80, 16'h0000, 16'h0002, 16'h0000);
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'h0000);
    push_request(MODE_FC03, 8'h80, 16'h00FF, 16'h0001, 16'h0000);
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'hA5A5);
    // An open frame closed by a bad header.
    push_request(MODE_FC16_HDR, 8'h22, 16'h1000, 16'h0003, 16'h0000);
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'h5A5A);
    push_request(MODE_FC16_HDR, 8'h22, 16'h1000, 16'h0000, 16'h0000);
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'h0F0F);
    // The largest count, with its byte count at 246, abandoned by a write.
    push_request(MODE_FC16_HDR, 8'h33, 16'h2000, 16'(MAX_WRITE_REGS), 16'h0000);
    push_request(MODE_FC16_VAL, 8'h00, 16'h0000, 16'h0000, 16'hF0F0);
    push_request(MODE_FC06, 8'h33, 16'h2000, 16'h0000, 16'h8001);

    // One frame at the largest count, which may be cut short, then a random mix
    // where most transactions belong to well-formed FC16 writes.
    send_write_sequence(MAX_WRITE_REGS);
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)
        send_write_sequence(($urandom_range(0, 19) == 0) ?
                            $urandom_range(9, MAX_WRITE_REGS) : $urandom_range(1, 8));
      else if (pick < 80)
        send_read_or_write();
      else if (pick < 90)
        send_bad_header();
      else if (pick < 95)
        send_value();
      else
        send_unknown_mode();
    end
    in_push = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
